@@ rtl/core/lsc_pkg.sv @@
package lsc_pkg;

	localparam int COORD_BITS_DEF = 24;
	localparam int QUEUE_DEPTH = 2;

	typedef enum logic [1:0] {
		CFG_LEFT,
		CFG_RIGHT,
		CFG_BOTTOM,
		CFG_TOP
	} cfg_index_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_STEP,
		BK_MUL,
		BK_DIV,
		BK_APPLY,
		BK_DONE
	} back_state_t;

	typedef struct packed {
		logic push;
		logic pop;
		logic full;
		logic empty;
	} queue_ctrl_t;

endpackage

@@ rtl/core/lsc_front.sv @@
module lsc_front #(
	parameter int COORD_BITS = lsc_pkg::COORD_BITS_DEF
) (
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic signed [COORD_BITS-1:0] start_x,
	input  logic signed [COORD_BITS-1:0] start_y,
	input  logic signed [COORD_BITS-1:0] end_x,
	input  logic signed [COORD_BITS-1:0] end_y,
	input  logic signed [COORD_BITS-1:0] clip_left,
	input  logic signed [COORD_BITS-1:0] clip_right,
	input  logic signed [COORD_BITS-1:0] clip_bottom,
	input  logic signed [COORD_BITS-1:0] clip_top,
	input  logic                         q_full,
	output logic                         q_push,
	output logic [4*COORD_BITS:0]        q_wdata
);
	import lsc_pkg::*;

	logic reject;

	// both endpoints strictly beyond the same edge
	always_comb begin
		reject = (start_x < clip_left && end_x < clip_left) ||
			(start_x > clip_right && end_x > clip_right) ||
			(start_y < clip_bottom && end_y < clip_bottom) ||
			(start_y > clip_top && end_y > clip_top);
	end

	assign in_stall = q_full;
	assign q_push   = in_valid && !q_full;
	assign q_wdata  = {reject, start_x, start_y, end_x, end_y};

endmodule

@@ rtl/core/lsc_queue.sv @@
module lsc_queue #(
	parameter int WIDTH = 4 * lsc_pkg::COORD_BITS_DEF + 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             full,
	output logic             empty
);
	import lsc_pkg::*;

	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam logic [CW-1:0] CNT_FULL = CW'(QUEUE_DEPTH);
	localparam logic [PW-1:0] PTR_LAST = PW'(QUEUE_DEPTH - 1);

	logic [WIDTH-1:0] entry_q [QUEUE_DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;

	assign full  = (count_q == CNT_FULL);
	assign empty = (count_q == '0);
	assign rdata = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

@@ rtl/core/lsc_back.sv @@
module lsc_back #(
	parameter int COORD_BITS = lsc_pkg::COORD_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic signed [COORD_BITS-1:0] clip_left,
	input  logic signed [COORD_BITS-1:0] clip_right,
	input  logic signed [COORD_BITS-1:0] clip_bottom,
	input  logic signed [COORD_BITS-1:0] clip_top,
	input  logic [4*COORD_BITS:0]        q_rdata,
	input  logic                         q_empty,
	output logic                         q_pop,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic signed [COORD_BITS-1:0] clipped_start_x,
	output logic signed [COORD_BITS-1:0] clipped_start_y,
	output logic signed [COORD_BITS-1:0] clipped_end_x,
	output logic signed [COORD_BITS-1:0] clipped_end_y,
	output logic                         rejected
);
	import lsc_pkg::*;

	localparam int W  = COORD_BITS;
	localparam int W1 = COORD_BITS + 1;
	localparam int CW = $clog2(W1);
	localparam logic [CW-1:0] CNT_LAST = CW'(W1 - 1);

	back_state_t state_q, state_d;

	logic signed [W-1:0] x0_q, y0_q, x1_q, y1_q;
	logic                rej_q;
	logic [2:0]          k_q;
	logic [CW-1:0]       cnt_q;
	logic [W1-1:0]       m_q, n_q, d_q, rem_q, quo_q;
	logic [2*W1-1:0]     prod_q;
	logic                neg_q;

	logic signed [W-1:0]  a0, a1, b0, b1, edg;
	logic signed [W1-1:0] da, db, de, res;
	logic [W1-1:0]        mag_da, mag_db, mag_de, r_cur;
	logic [W1:0]          trial;
	logic                 hit, move_start, qbit, load_out;

	// edge k: left, left, right, right, bottom, bottom, top, top
	always_comb begin
		if (!k_q[2]) begin
			b0 = x0_q; b1 = x1_q; a0 = y0_q; a1 = y1_q;
			edg = k_q[1] ? clip_right : clip_left;
		end else begin
			b0 = y0_q; b1 = y1_q; a0 = x0_q; a1 = x1_q;
			edg = k_q[1] ? clip_top : clip_bottom;
		end
		hit = k_q[0] ? (b1 <= edg && b0 > edg) : (b1 >= edg && b0 < edg);
		move_start = (k_q[0] == k_q[1]);
		da = {a1[W-1], a1} - {a0[W-1], a0};
		db = {b1[W-1], b1} - {b0[W-1], b0};
		de = {edg[W-1], edg} - {b0[W-1], b0};
		mag_da = da[W1-1] ? W1'(-da) : W1'(da);
		mag_db = db[W1-1] ? W1'(-db) : W1'(db);
		mag_de = de[W1-1] ? W1'(-de) : W1'(de);
		res = neg_q ? ({a0[W-1], a0} - $signed(quo_q)) : ({a0[W-1], a0} + $signed(quo_q));
		// restoring division step, first step takes the high product half
		r_cur = (cnt_q == '0) ? prod_q[2*W1-1:W1] : rem_q;
		trial = {r_cur, prod_q[W1-1]};
		qbit  = (trial >= {1'b0, d_q});
	end

	always_comb begin
		state_d  = state_q;
		q_pop    = 1'b0;
		load_out = 1'b0;
		case (state_q)
			BK_IDLE: begin
				if (!q_empty) begin
					q_pop   = 1'b1;
					state_d = q_rdata[4*W] ? BK_DONE : BK_STEP;
				end
			end
			BK_STEP: begin
				if (hit) begin
					state_d = BK_MUL;
				end else if (k_q == 3'd7) begin
					state_d = BK_DONE;
				end
			end
			BK_MUL: begin
				if (cnt_q == CNT_LAST) begin
					state_d = BK_DIV;
				end
			end
			BK_DIV: begin
				if (cnt_q == CNT_LAST) begin
					state_d = BK_APPLY;
				end
			end
			BK_APPLY: begin
				state_d = (k_q == 3'd7) ? BK_DONE : BK_STEP;
			end
			BK_DONE: begin
				if (!out_valid || !out_stall) begin
					load_out = 1'b1;
					state_d  = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= BK_IDLE;
			out_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_out) begin
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			BK_IDLE: begin
				rej_q <= q_rdata[4*W];
				x0_q  <= q_rdata[4*W-1:3*W];
				y0_q  <= q_rdata[3*W-1:2*W];
				x1_q  <= q_rdata[2*W-1:W];
				y1_q  <= q_rdata[W-1:0];
				k_q   <= '0;
			end
			BK_STEP: begin
				if (hit) begin
					m_q    <= mag_da;
					n_q    <= mag_de;
					d_q    <= mag_db;
					neg_q  <= da[W1-1] ^ de[W1-1] ^ db[W1-1];
					prod_q <= '0;
					cnt_q  <= '0;
				end else begin
					k_q <= k_q + 3'd1;
				end
			end
			BK_MUL: begin
				prod_q <= {prod_q[2*W1-2:0], 1'b0} + {{W1{1'b0}}, (n_q[W1-1] ? m_q : '0)};
				n_q    <= {n_q[W1-2:0], 1'b0};
				cnt_q  <= (cnt_q == CNT_LAST) ? '0 : cnt_q + 1'b1;
			end
			BK_DIV: begin
				rem_q  <= qbit ? W1'(trial - {1'b0, d_q}) : trial[W1-1:0];
				quo_q  <= {quo_q[W1-2:0], qbit};
				prod_q <= {prod_q[2*W1-1:W1], prod_q[W1-2:0], 1'b0};
				cnt_q  <= (cnt_q == CNT_LAST) ? '0 : cnt_q + 1'b1;
			end
			BK_APPLY: begin
				case ({k_q[2], move_start})
					2'b01: begin y0_q <= res[W-1:0]; x0_q <= edg; end
					2'b00: begin y1_q <= res[W-1:0]; x1_q <= edg; end
					2'b11: begin x0_q <= res[W-1:0]; y0_q <= edg; end
					default: begin x1_q <= res[W-1:0]; y1_q <= edg; end
				endcase
				k_q <= k_q + 3'd1;
			end
			BK_DONE: begin
				if (load_out) begin
					// a rejected segment collapses to its end point
					clipped_start_x <= rej_q ? x1_q : x0_q;
					clipped_start_y <= rej_q ? y1_q : y0_q;
					clipped_end_x   <= x1_q;
					clipped_end_y   <= y1_q;
					rejected        <= rej_q;
				end
			end
			default: ;
		endcase
	end

endmodule

@@ rtl/core/line_segment_clipper_unit.sv @@
// a rejected segment passes from the queue straight to the done state; any other segment steps
// through the edge checks with a multiply and a divide per crossed edge (up to four crossings)
// the back sequencer works on one segment at a time and pops the next only after loading a result;
// its shared shift-add multiplier and restoring divider set the pace, and a two-entry queue lets
// the front accept while the back is busy
// reset: arst_n asynchronous active low clears queue, sequencer, out_valid; clip rect to 0..MAX_POS
module line_segment_clipper_unit #(
	parameter int COORD_BITS = lsc_pkg::COORD_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  lsc_pkg::cfg_index_t          cfg_index,
	input  logic [COORD_BITS-1:0]        cfg_data,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic signed [COORD_BITS-1:0] start_x,
	input  logic signed [COORD_BITS-1:0] start_y,
	input  logic signed [COORD_BITS-1:0] end_x,
	input  logic signed [COORD_BITS-1:0] end_y,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic signed [COORD_BITS-1:0] clipped_start_x,
	output logic signed [COORD_BITS-1:0] clipped_start_y,
	output logic signed [COORD_BITS-1:0] clipped_end_x,
	output logic signed [COORD_BITS-1:0] clipped_end_y,
	output logic                         rejected
);
	import lsc_pkg::*;

	localparam int W = COORD_BITS;
	localparam logic [W-1:0] MAX_POS = {1'b0, {(W-1){1'b1}}};

	logic signed [W-1:0] clip_left_q, clip_right_q, clip_bottom_q, clip_top_q;
	logic [4*W:0]        q_wdata, q_rdata;
	queue_ctrl_t         qc;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clip_left_q   <= '0;
			clip_right_q  <= MAX_POS;
			clip_bottom_q <= '0;
			clip_top_q    <= MAX_POS;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_LEFT:   clip_left_q   <= cfg_data;
				CFG_RIGHT:  clip_right_q  <= cfg_data;
				CFG_BOTTOM: clip_bottom_q <= cfg_data;
				CFG_TOP:    clip_top_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	lsc_front #(.COORD_BITS(COORD_BITS)) u_front (
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.start_x     (start_x),
		.start_y     (start_y),
		.end_x       (end_x),
		.end_y       (end_y),
		.clip_left   (clip_left_q),
		.clip_right  (clip_right_q),
		.clip_bottom (clip_bottom_q),
		.clip_top    (clip_top_q),
		.q_full      (qc.full),
		.q_push      (qc.push),
		.q_wdata     (q_wdata)
	);

	lsc_queue #(.WIDTH(4 * COORD_BITS + 1)) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (qc.push),
		.wdata  (q_wdata),
		.pop    (qc.pop),
		.rdata  (q_rdata),
		.full   (qc.full),
		.empty  (qc.empty)
	);

	lsc_back #(.COORD_BITS(COORD_BITS)) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.clip_left       (clip_left_q),
		.clip_right      (clip_right_q),
		.clip_bottom     (clip_bottom_q),
		.clip_top        (clip_top_q),
		.q_rdata         (q_rdata),
		.q_empty         (qc.empty),
		.q_pop           (qc.pop),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.clipped_start_x (clipped_start_x),
		.clipped_start_y (clipped_start_y),
		.clipped_end_x   (clipped_end_x),
		.clipped_end_y   (clipped_end_y),
		.rejected        (rejected)
	);

`ifndef SYNTHESIS
	assert property (@(posedge clk) disable iff (!arst_n) qc.pop |-> !qc.empty)
		else $error("queue popped while empty");
	assert property (@(posedge clk) disable iff (!arst_n) qc.push |-> !qc.full)
		else $error("queue pushed while full");
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && rejected) |-> (clipped_start_x == clipped_end_x &&
		clipped_start_y == clipped_end_y))
		else $error("rejected segment not collapsed to end point");
`endif

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
	import lsc_pkg::*;

	localparam int CW = COORD_BITS_DEF;
	localparam longint CMAX = (longint'(1) << (CW - 1)) - 1;
	localparam longint CMIN = -(longint'(1) << (CW - 1));
	localparam int IDLE_LIMIT = 6000;

	typedef logic signed [CW-1:0] coord_t;

	typedef struct {
		coord_t sx;
		coord_t sy;
		coord_t ex;
		coord_t ey;
		logic   rej;
	} clip_seg_t;

	logic   clk;
	logic   arst_n;
	logic   cfg_valid;
	logic   cfg_ready;
	cfg_index_t cfg_index;
	logic [CW-1:0] cfg_data;
	logic   in_valid;
	logic   in_stall;
	coord_t start_x, start_y, end_x, end_y;
	logic   out_valid;
	logic   out_stall;
	coord_t clipped_start_x, clipped_start_y, clipped_end_x, clipped_end_y;
	logic   rejected;

	// clip rectangle as the bench believes it
	coord_t rect_left, rect_right, rect_bottom, rect_top;

	clip_seg_t expected_segs[$];
	int fail_count;
	int idle_cycles;
	int burst_left;
	int stall_pct;
	int stall_phase;

	line_segment_clipper_unit #(.COORD_BITS(CW)) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.start_x(start_x),
		.start_y(start_y),
		.end_x(end_x),
		.end_y(end_y),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.clipped_start_x(clipped_start_x),
		.clipped_start_y(clipped_start_y),
		.clipped_end_x(clipped_end_x),
		.clipped_end_y(clipped_end_y),
		.rejected(rejected)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// a0 + (a1 - a0) * (bound - b0) / (b1 - b0), truncated toward zero
	function automatic longint lerp_coord(longint a0, longint a1, longint b0, longint b1,
			longint bound);
		longint da, db, de, q;
		bit neg;
		da = a1 - a0;
		db = b1 - b0;
		de = bound - b0;
		if (db == 0 || da == 0 || de == 0) begin
			return a0;
		end
		q = ((da < 0 ? -da : da) * (de < 0 ? -de : de)) / (db < 0 ? -db : db);
		neg = ((da < 0) != (de < 0)) != (db < 0);
		return neg ? a0 - q : a0 + q;
	endfunction

	function automatic clip_seg_t clip_segment(coord_t ax, coord_t ay, coord_t bx, coord_t by);
		longint x0, y0, x1, y1, l, r, b, t;
		clip_seg_t res;
		x0 = ax; y0 = ay; x1 = bx; y1 = by;
		l = rect_left; r = rect_right; b = rect_bottom; t = rect_top;
		res.rej = 1'b0;
		if ((x0 < l && x1 < l) || (x0 > r && x1 > r) ||
				(y0 < b && y1 < b) || (y0 > t && y1 > t)) begin
			x0 = x1;
			y0 = y1;
			res.rej = 1'b1;
		end else begin
			if (x1 >= l && x0 < l) begin y0 = lerp_coord(y0, y1, x0, x1, l); x0 = l; end
			if (x1 <= l && x0 > l) begin y1 = lerp_coord(y0, y1, x0, x1, l); x1 = l; end
			if (x1 >= r && x0 < r) begin y1 = lerp_coord(y0, y1, x0, x1, r); x1 = r; end
			if (x1 <= r && x0 > r) begin y0 = lerp_coord(y0, y1, x0, x1, r); x0 = r; end
			if (y1 >= b && y0 < b) begin x0 = lerp_coord(x0, x1, y0, y1, b); y0 = b; end
			if (y1 <= b && y0 > b) begin x1 = lerp_coord(x0, x1, y0, y1, b); y1 = b; end
			if (y1 >= t && y0 < t) begin x1 = lerp_coord(x0, x1, y0, y1, t); y1 = t; end
			if (y1 <= t && y0 > t) begin x0 = lerp_coord(x0, x1, y0, y1, t); y0 = t; end
		end
		res.sx = coord_t'(x0);
		res.sy = coord_t'(y0);
		res.ex = coord_t'(x1);
		res.ey = coord_t'(y1);
		return res;
	endfunction

	function automatic coord_t clamp_coord(longint v);
		if (v > CMAX) begin
			return coord_t'(CMAX);
		end
		if (v < CMIN) begin
			return coord_t'(CMIN);
		end
		return coord_t'(v);
	endfunction

	// mostly around the given span, with edges, extremes and raw noise mixed in
	function automatic coord_t pick_coord(coord_t lo, coord_t hi);
		longint l, h, span;
		int sel;
		l = lo;
		h = hi;
		if (l > h) begin
			span = l; l = h; h = span;
		end
		span = h - l + 16;
		sel = $urandom_range(0, 99);
		if (sel < 55) begin
			return clamp_coord(l - span + longint'($urandom_range(0, 32'(3 * span))));
		end else if (sel < 70) begin
			return ($urandom_range(0, 1) == 1) ? lo : hi;
		end else if (sel < 80) begin
			return ($urandom_range(0, 1) == 1) ? coord_t'(CMAX) : coord_t'(CMIN);
		end
		return coord_t'($urandom);
	endfunction

	task automatic send_segment(coord_t ax, coord_t ay, coord_t bx, coord_t by);
		int gap;
		@(negedge clk);
		in_valid = 1'b1;
		start_x = ax;
		start_y = ay;
		end_x = bx;
		end_y = by;
		do @(posedge clk); while (in_stall);
		expected_segs.push_back(clip_segment(ax, ay, bx, by));
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 20);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
			if (gap > 0) begin
				@(negedge clk);
				in_valid = 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
	endtask

	task automatic drain_results();
		// drop valid before the next edge so the last transaction is not taken again
		@(negedge clk);
		in_valid = 1'b0;
		while (expected_segs.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(cfg_index_t idx, coord_t value);
		@(negedge clk);
		in_valid = 1'b0;
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = value;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_LEFT:   rect_left = value;
			CFG_RIGHT:  rect_right = value;
			CFG_BOTTOM: rect_bottom = value;
			CFG_TOP:    rect_top = value;
			default: ;
		endcase
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic set_rect(coord_t l, coord_t r, coord_t b, coord_t t);
		drain_results();
		write_reg(CFG_LEFT, l);
		write_reg(CFG_RIGHT, r);
		write_reg(CFG_BOTTOM, b);
		write_reg(CFG_TOP, t);
	endtask

	task automatic test_reset_rect();
		send_segment(-24'sd100, 24'sd50, 24'sd300, 24'sd400);
		send_segment(coord_t'(CMIN), coord_t'(CMIN), coord_t'(CMAX), coord_t'(CMAX));
		send_segment(-24'sd5, -24'sd5, -24'sd1, 24'sd9);
		send_segment(24'sd0, 24'sd0, coord_t'(CMAX), coord_t'(CMAX));
	endtask

	task automatic test_directed_edges();
		set_rect(-24'sd2560, 24'sd2560, -24'sd1280, 24'sd1280);
		// trivial reject beyond each edge
		send_segment(-24'sd3000, 24'sd0, -24'sd2600, 24'sd100);
		send_segment(24'sd3000, -24'sd10, 24'sd9000, 24'sd10);
		send_segment(24'sd0, -24'sd2000, 24'sd10, -24'sd1300);
		send_segment(24'sd5, 24'sd2000, -24'sd5, 24'sd1281);
		// fully inside and on the edges
		send_segment(-24'sd100, 24'sd7, 24'sd333, -24'sd99);
		send_segment(-24'sd2560, -24'sd1280, 24'sd2560, 24'sd1280);
		// crossing each edge, in both directions for left, right and bottom
		send_segment(-24'sd4000, 24'sd100, 24'sd0, 24'sd300);
		send_segment(24'sd0, 24'sd300, -24'sd4000, 24'sd100);
		send_segment(24'sd0, -24'sd77, 24'sd5111, 24'sd91);
		send_segment(24'sd5111, 24'sd91, 24'sd0, -24'sd77);
		send_segment(24'sd13, -24'sd3001, -24'sd17, 24'sd3);
		send_segment(-24'sd17, 24'sd3, 24'sd13, -24'sd3001);
		send_segment(24'sd200, 24'sd0, -24'sd201, 24'sd2999);
		// corner to corner, beyond all edges, and a single point
		send_segment(coord_t'(CMIN), coord_t'(CMIN), coord_t'(CMAX), coord_t'(CMAX));
		send_segment(coord_t'(CMAX), coord_t'(CMIN), coord_t'(CMIN), coord_t'(CMAX));
		send_segment(-24'sd3000, 24'sd0, 24'sd0, 24'sd5000);
		send_segment(24'sd10, 24'sd10, 24'sd10, 24'sd10);
		// inverted rectangle
		set_rect(24'sd1000, -24'sd1000, 24'sd500, -24'sd500);
		send_segment(-24'sd2000, -24'sd700, 24'sd2000, 24'sd700);
		send_segment(24'sd0, 24'sd0, 24'sd10, 24'sd20);
		send_segment(24'sd1500, 24'sd0, -24'sd1500, 24'sd0);
	endtask

	task automatic test_random_segments(int count);
		coord_t lo_x, hi_x, lo_y, hi_y;
		lo_x = rect_left; hi_x = rect_right; lo_y = rect_bottom; hi_y = rect_top;
		repeat (count) begin
			send_segment(pick_coord(lo_x, hi_x), pick_coord(lo_y, hi_y),
				pick_coord(lo_x, hi_x), pick_coord(lo_y, hi_y));
		end
	endtask

	task automatic test_random_rects();
		coord_t a, b, c, d;
		set_rect(-24'sd640, 24'sd640, -24'sd320, 24'sd960);
		test_random_segments(170);
		set_rect(coord_t'(CMIN), coord_t'(CMAX), coord_t'(CMIN), coord_t'(CMAX));
		test_random_segments(120);
		set_rect(coord_t'(CMAX), coord_t'(CMAX), coord_t'(CMIN), coord_t'(CMIN));
		test_random_segments(80);
		set_rect(24'sd300, 24'sd300, -24'sd40, 24'sd40);
		test_random_segments(100);
		set_rect(24'sd900, -24'sd900, 24'sd50, -24'sd50);
		test_random_segments(100);
		repeat (4) begin
			a = coord_t'($urandom);
			b = coord_t'($urandom);
			c = coord_t'($urandom_range(0, 20000)) - 24'sd10000;
			d = c + coord_t'($urandom_range(0, 8000));
			if (a > b) begin
				set_rect(b, a, c, d);
			end else begin
				set_rect(a, b, c, d);
			end
			test_random_segments(95);
		end
	endtask

	// receiver stall pattern: duty of 0, 20, 50 or 85 percent, redrawn when its random phase runs out
	always @(negedge clk) begin
		if (stall_phase == 0) begin
			case ($urandom_range(0, 3))
				0: stall_pct = 0;
				1: stall_pct = 20;
				2: stall_pct = 50;
				default: stall_pct = 85;
			endcase
			stall_phase = $urandom_range(50, 300);
		end else begin
			stall_phase--;
		end
		out_stall = ($urandom_range(0, 99) < stall_pct);
	end

	always @(posedge clk) begin
		clip_seg_t exp_seg;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_segs.size() == 0) begin
				$display("%0t: result transaction with nothing expected", $time);
				fail_count++;
			end else begin
				exp_seg = expected_segs.pop_front();
				if (clipped_start_x !== exp_seg.sx) begin
					$display("%0t: clipped_start_x expected %0d actual %0d",
						$time, exp_seg.sx, clipped_start_x);
					fail_count++;
				end
				if (clipped_start_y !== exp_seg.sy) begin
					$display("%0t: clipped_start_y expected %0d actual %0d",
						$time, exp_seg.sy, clipped_start_y);
					fail_count++;
				end
				if (clipped_end_x !== exp_seg.ex) begin
					$display("%0t: clipped_end_x expected %0d actual %0d",
						$time, exp_seg.ex, clipped_end_x);
					fail_count++;
				end
				if (clipped_end_y !== exp_seg.ey) begin
					$display("%0t: clipped_end_y expected %0d actual %0d",
						$time, exp_seg.ey, clipped_end_y);
					fail_count++;
				end
				if (rejected !== exp_seg.rej) begin
					$display("%0t: rejected expected %0b actual %0b",
						$time, exp_seg.rej, rejected);
					fail_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
				(cfg_valid && cfg_ready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = CFG_LEFT;
		cfg_data = '0;
		in_valid = 1'b0;
		start_x = '0;
		start_y = '0;
		end_x = '0;
		end_y = '0;
		out_stall = 1'b0;
		stall_pct = 0;
		stall_phase = 0;
		burst_left = 0;
		fail_count = 0;
		idle_cycles = 0;
		rect_left = '0;
		rect_right = coord_t'(CMAX);
		rect_bottom = '0;
		rect_top = coord_t'(CMAX);
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_rect();
		test_directed_edges();
		test_random_rects();

		drain_results();
		repeat (250) @(posedge clk);
		if (fail_count == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
